// ===== hw/rtl/spq_pkg.sv =====
package spq_pkg;

  localparam int unsigned DEPTH_DEF     = 16;
  localparam int unsigned ID_BITS_DEF   = 16;
  localparam int unsigned PRIO_BITS_DEF = 8;

  localparam int unsigned ACT_W  = 2;
  localparam int unsigned ID_W   = 16;
  localparam int unsigned PRIO_W = 8;
  localparam int unsigned STAT_W = 2;

  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_POP    = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_DUMP   = 2'd3
  } action_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_EMPTY   = 2'd1,
    STAT_MISSING = 2'd2,
    STAT_FULL    = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    CELL_HOLD   = 3'd0,
    CELL_INSERT = 3'd1,
    CELL_POP    = 3'd2,
    CELL_REMOVE = 3'd3,
    CELL_ROTATE = 3'd4
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    logic     load_hit;
  } cell_ctrl_t;

endpackage

// ===== hw/rtl/spq_cell.sv =====
module spq_cell #(
  parameter int unsigned ID_BITS   = 16,
  parameter int unsigned PRIO_BITS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  spq_pkg::cell_ctrl_t   ctrl_i,
  input  logic [ID_BITS-1:0]    new_id_i,
  input  logic [PRIO_BITS-1:0]  new_prio_i,
  input  logic [ID_BITS-1:0]    search_id_i,
  input  logic [ID_BITS-1:0]    head_id_i,
  input  logic [PRIO_BITS-1:0]  head_prio_i,
  input  logic                  left_keep_i,
  input  logic                  left_valid_i,
  input  logic [ID_BITS-1:0]    left_id_i,
  input  logic [PRIO_BITS-1:0]  left_prio_i,
  input  logic                  right_valid_i,
  input  logic [ID_BITS-1:0]    right_id_i,
  input  logic [PRIO_BITS-1:0]  right_prio_i,
  input  logic                  shift_i,
  output logic                  valid_o,
  output logic [ID_BITS-1:0]    id_o,
  output logic [PRIO_BITS-1:0]  prio_o,
  output logic                  keep_o,
  output logic                  hit_o
);
  import spq_pkg::*;

  logic                 valid_q, valid_d;
  logic [ID_BITS-1:0]   id_q, id_d;
  logic [PRIO_BITS-1:0] prio_q, prio_d;
  logic                 hit_q, hit_d;

  assign keep_o  = valid_q && (prio_q >= new_prio_i);
  assign valid_o = valid_q;
  assign id_o    = id_q;
  assign prio_o  = prio_q;
  assign hit_o   = hit_q;

  always_comb begin
    valid_d = valid_q;
    id_d    = id_q;
    prio_d  = prio_q;
    hit_d   = hit_q;
    if (ctrl_i.load_hit) begin
      hit_d = valid_q && (id_q == search_id_i);
    end
    case (ctrl_i.op)
      CELL_HOLD: begin
      end
      CELL_INSERT: begin
        if (!keep_o) begin
          if (left_keep_i) begin
            valid_d = 1'b1;
            id_d    = new_id_i;
            prio_d  = new_prio_i;
          end else begin
            valid_d = left_valid_i;
            id_d    = left_id_i;
            prio_d  = left_prio_i;
          end
        end
      end
      CELL_POP: begin
        valid_d = right_valid_i;
        id_d    = right_id_i;
        prio_d  = right_prio_i;
      end
      CELL_REMOVE: begin
        if (shift_i) begin
          valid_d = right_valid_i;
          id_d    = right_id_i;
          prio_d  = right_prio_i;
        end
      end
      CELL_ROTATE: begin
        if (valid_q) begin
          if (right_valid_i) begin
            id_d   = right_id_i;
            prio_d = right_prio_i;
          end else begin
            id_d   = head_id_i;
            prio_d = head_prio_i;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      hit_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      hit_q   <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q   <= id_d;
    prio_q <= prio_d;
  end

endmodule

// ===== hw/rtl/sorted_priority_queue_with_delete.sv =====
// Priority queue of up to DEPTH (id, priority) entries held in a chain of cells, sorted by
// descending priority with ties kept in arrival order. Every transaction is taken into a
// command register in the cycle it is accepted, and each cell compares its id with the
// incoming id in that same cycle; in the EXEC state that follows, once the result register
// is free, the command executes across the whole chain at once and an insert, pop or remove
// registers its result. No new transaction is accepted until the block is back in IDLE.
// In a dump the chain rotates one step per cycle while the result register is free and
// presents its head entry each time, the last one flagged; an empty store gives one empty
// status instead. Status reports an empty store, a missing id or a full store. Reset clears
// the valid, hit, state, count, index and output valid registers, not ids or priorities.
module sorted_priority_queue_with_delete #(
  parameter int unsigned DEPTH     = spq_pkg::DEPTH_DEF,
  parameter int unsigned ID_BITS   = spq_pkg::ID_BITS_DEF,
  parameter int unsigned PRIO_BITS = spq_pkg::PRIO_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [spq_pkg::ACT_W-1:0]   action_i,
  input  logic [spq_pkg::ID_W-1:0]    task_id_i,
  input  logic [spq_pkg::PRIO_W-1:0]  task_priority_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [spq_pkg::STAT_W-1:0]  status_o,
  output logic [spq_pkg::ID_W-1:0]    out_id_o,
  output logic [spq_pkg::PRIO_W-1:0]  out_priority_o,
  output logic                        last_o
);
  import spq_pkg::*;

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_DUMP = 3'b100
  } state_e;

  state_e               state_q, state_d;
  action_e              act_q;
  logic [ID_BITS-1:0]   cmd_id_q;
  logic [PRIO_BITS-1:0] cmd_prio_q;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [CNT_W-1:0]     idx_q, idx_d;

  logic                 out_valid_q;
  status_e              status_q, status_d;
  logic [ID_W-1:0]      out_id_q, out_id_d;
  logic [PRIO_W-1:0]    out_prio_q, out_prio_d;
  logic                 last_q, last_d;
  logic                 emit;

  logic                 accept;
  logic                 out_free;
  logic                 full;
  logic                 empty;
  cell_ctrl_t           ctrl;

  logic [DEPTH-1:0]     valid_w;
  logic [DEPTH-1:0]     keep_w;
  logic [DEPTH-1:0]     hit_w;
  logic [DEPTH-1:0]     hit_neg;
  logic [DEPTH-1:0]     first_w;
  logic [DEPTH-1:0]     shift_w;
  logic [ID_BITS-1:0]   id_w   [DEPTH];
  logic [PRIO_BITS-1:0] prio_w [DEPTH];
  logic [ID_BITS-1:0]   sel_id;
  logic [PRIO_BITS-1:0] sel_prio;
  logic [ID_BITS-1:0]   search_id;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign full       = (count_q == CNT_W'(DEPTH));
  assign empty      = (count_q == '0);
  assign search_id  = ID_BITS'(task_id_i);

  // The lowest set bit of the hit vector marks the first match from the head; every cell at
  // or behind it pulls its right neighbor to close the gap.
  assign hit_neg = ~hit_w + DEPTH'(1);
  assign first_w = hit_w & hit_neg;
  assign shift_w = hit_w | hit_neg;

  always_comb begin
    sel_id   = '0;
    sel_prio = '0;
    for (int i = 0; i < DEPTH; i++) begin
      sel_id   = sel_id   | ({ID_BITS{first_w[i]}}   & id_w[i]);
      sel_prio = sel_prio | ({PRIO_BITS{first_w[i]}} & prio_w[i]);
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                 left_keep;
    logic                 left_valid;
    logic [ID_BITS-1:0]   left_id;
    logic [PRIO_BITS-1:0] left_prio;
    logic                 right_valid;
    logic [ID_BITS-1:0]   right_id;
    logic [PRIO_BITS-1:0] right_prio;

    if (i == 0) begin : g_head
      assign left_keep  = 1'b1;
      assign left_valid = 1'b0;
      assign left_id    = '0;
      assign left_prio  = '0;
    end else begin : g_body
      assign left_keep  = keep_w[i-1];
      assign left_valid = valid_w[i-1];
      assign left_id    = id_w[i-1];
      assign left_prio  = prio_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_valid = 1'b0;
      assign right_id    = '0;
      assign right_prio  = '0;
    end else begin : g_next
      assign right_valid = valid_w[i+1];
      assign right_id    = id_w[i+1];
      assign right_prio  = prio_w[i+1];
    end

    spq_cell #(
      .ID_BITS  (ID_BITS),
      .PRIO_BITS(PRIO_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .new_id_i     (cmd_id_q),
      .new_prio_i   (cmd_prio_q),
      .search_id_i  (search_id),
      .head_id_i    (id_w[0]),
      .head_prio_i  (prio_w[0]),
      .left_keep_i  (left_keep),
      .left_valid_i (left_valid),
      .left_id_i    (left_id),
      .left_prio_i  (left_prio),
      .right_valid_i(right_valid),
      .right_id_i   (right_id),
      .right_prio_i (right_prio),
      .shift_i      (shift_w[i]),
      .valid_o      (valid_w[i]),
      .id_o         (id_w[i]),
      .prio_o       (prio_w[i]),
      .keep_o       (keep_w[i]),
      .hit_o        (hit_w[i])
    );
  end

  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    idx_d         = idx_q;
    ctrl.op       = CELL_HOLD;
    ctrl.load_hit = accept;
    emit          = 1'b0;
    status_d      = STAT_OK;
    out_id_d      = '0;
    out_prio_d    = '0;
    last_d        = 1'b1;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (act_q == ACT_DUMP && !empty) begin
          state_d = ST_DUMP;
          idx_d   = '0;
        end else if (out_free) begin
          emit    = 1'b1;
          state_d = ST_IDLE;
          case (act_q)
            ACT_INSERT: begin
              if (full) begin
                status_d = STAT_FULL;
              end else begin
                ctrl.op = CELL_INSERT;
                count_d = count_q + CNT_W'(1);
              end
            end
            ACT_POP: begin
              if (empty) begin
                status_d = STAT_EMPTY;
              end else begin
                out_id_d   = ID_W'(id_w[0]);
                out_prio_d = PRIO_W'(prio_w[0]);
                ctrl.op    = CELL_POP;
                count_d    = count_q - CNT_W'(1);
              end
            end
            ACT_REMOVE: begin
              if (empty) begin
                status_d = STAT_EMPTY;
              end else if (|hit_w) begin
                out_id_d   = ID_W'(sel_id);
                out_prio_d = PRIO_W'(sel_prio);
                ctrl.op    = CELL_REMOVE;
                count_d    = count_q - CNT_W'(1);
              end else begin
                status_d = STAT_MISSING;
              end
            end
            ACT_DUMP: begin
              status_d = STAT_EMPTY;
            end
            default: begin
            end
          endcase
        end
      end
      ST_DUMP: begin
        if (out_free) begin
          emit       = 1'b1;
          out_id_d   = ID_W'(id_w[0]);
          out_prio_d = PRIO_W'(prio_w[0]);
          ctrl.op    = CELL_ROTATE;
          last_d     = (idx_q == count_q - CNT_W'(1));
          if (last_d) begin
            state_d = ST_IDLE;
          end else begin
            idx_d = idx_q + CNT_W'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q      <= action_e'(action_i);
      cmd_id_q   <= ID_BITS'(task_id_i);
      cmd_prio_q <= PRIO_BITS'(task_priority_i);
    end
    if (emit) begin
      status_q   <= status_d;
      out_id_q   <= out_id_d;
      out_prio_q <= out_prio_d;
      last_q     <= last_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign out_id_o       = out_id_q;
  assign out_priority_o = out_prio_q;
  assign last_o         = last_q;

`ifndef SYNTHESIS
  a_count_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_w) == count_q)
    else $error("Entry count disagrees with the cell valid flags.");

  a_valid_packed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_w & (valid_w + DEPTH'(1))) == '0)
    else $error("Valid cells are not packed toward the head.");

  a_dump_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DUMP |-> count_q != '0)
    else $error("Dump in progress on an empty store.");

  a_no_change_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |=> count_q == $past(count_q))
    else $error("Entry count changed without a transaction being executed.");
`endif

endmodule

// ===== test/testbench.sv =====
module testbench;
  import spq_pkg::*;

  localparam int unsigned SLOTS = DEPTH_DEF;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 2 * SLOTS + 8;

  typedef struct packed {
    status_e           status;
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
    logic              last;
  } queue_result_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [ACT_W-1:0]  action_i;
  logic [ID_W-1:0]   task_id_i;
  logic [PRIO_W-1:0] task_priority_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [STAT_W-1:0] status_o;
  logic [ID_W-1:0]   out_id_o;
  logic [PRIO_W-1:0] out_priority_o;
  logic              last_o;

  logic [ID_W-1:0]   stored_ids [SLOTS];
  logic [PRIO_W-1:0] stored_prios [SLOTS];
  int unsigned       stored_count = 0;
  queue_result_t     pending_results [$];

  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_left = 0;
  bit          sender_idle_en = 1'b1;
  bit          receiver_idle_en = 1'b1;

  sorted_priority_queue_with_delete dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .action_i        (action_i),
    .task_id_i       (task_id_i),
    .task_priority_i (task_priority_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .out_id_o        (out_id_o),
    .out_priority_o  (out_priority_o),
    .last_o          (last_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // The receiver either serves a requested hold-off or, while random idling is enabled, stalls at random.
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall_i <= receiver_idle_en && ($urandom_range(99) < 12);
    end
  end

  function automatic void push_result(status_e st, logic [ID_W-1:0] id,
                                      logic [PRIO_W-1:0] pr, logic fin);
    queue_result_t r;
    r.status = st;
    r.id = id;
    r.prio = pr;
    r.last = fin;
    pending_results.push_back(r);
  endfunction

  function automatic void drop_entry(int unsigned pos);
    for (int unsigned i = pos; i + 1 < stored_count; i++) begin
      stored_ids[i] = stored_ids[i + 1];
      stored_prios[i] = stored_prios[i + 1];
    end
    stored_count--;
  endfunction

  function automatic void predict_queue(action_e act, logic [ID_W-1:0] id,
                                        logic [PRIO_W-1:0] pr);
    int unsigned pos;
    pos = 0;
    if (act == ACT_INSERT) begin
      if (stored_count >= SLOTS) begin
        push_result(STAT_FULL, '0, '0, 1'b1);
        return;
      end
      while (pos < stored_count && stored_prios[pos] >= pr) pos++;
      for (int unsigned i = stored_count; i > pos; i--) begin
        stored_ids[i] = stored_ids[i - 1];
        stored_prios[i] = stored_prios[i - 1];
      end
      stored_ids[pos] = id;
      stored_prios[pos] = pr;
      stored_count++;
      push_result(STAT_OK, '0, '0, 1'b1);
    end else if (stored_count == 0) begin
      push_result(STAT_EMPTY, '0, '0, 1'b1);
    end else if (act == ACT_POP) begin
      push_result(STAT_OK, stored_ids[0], stored_prios[0], 1'b1);
      drop_entry(0);
    end else if (act == ACT_REMOVE) begin
      while (pos < stored_count && stored_ids[pos] != id) pos++;
      if (pos < stored_count) begin
        push_result(STAT_OK, stored_ids[pos], stored_prios[pos], 1'b1);
        drop_entry(pos);
      end else begin
        push_result(STAT_MISSING, '0, '0, 1'b1);
      end
    end else begin
      for (int unsigned i = 0; i < stored_count; i++)
        push_result(STAT_OK, stored_ids[i], stored_prios[i], i + 1 == stored_count);
    end
  endfunction

  always @(posedge clk_i) begin
    queue_result_t exp_r;
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (pending_results.size() == 0) begin
        $error("unexpected transaction: status %0d id %h priority %h last %0d",
               status_o, out_id_o, out_priority_o, last_o);
        error_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (status_o !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, status_o);
          error_count++;
        end
        if (out_id_o !== exp_r.id) begin
          $error("out_id: expected %h, got %h", exp_r.id, out_id_o);
          error_count++;
        end
        if (out_priority_o !== exp_r.prio) begin
          $error("out_priority: expected %h, got %h", exp_r.prio, out_priority_o);
          error_count++;
        end
        if (last_o !== exp_r.last) begin
          $error("last: expected %0d, got %0d", exp_r.last, last_o);
          error_count++;
        end
      end
    end
  end

  task automatic send_command(action_e act, logic [ID_W-1:0] id, logic [PRIO_W-1:0] pr);
    while (sender_idle_en && $urandom_range(99) < 12) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i <= act;
    task_id_i <= id;
    task_priority_i <= pr;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    predict_queue(act, id, pr);
  endtask

  task automatic send_random_command();
    int unsigned insert_pct;
    int unsigned r;
    logic [ID_W-1:0] id;
    logic [PRIO_W-1:0] pr;
    insert_pct = (stored_count < SLOTS / 2) ? 55 : ((stored_count < SLOTS) ? 35 : 15);
    id = ($urandom_range(1) != 0) ? ID_W'($urandom) : ID_W'($urandom_range(7));
    case ($urandom_range(3))
      0: pr = PRIO_W'($urandom_range(100, 103));
      1: pr = ($urandom_range(1) != 0) ? '1 : '0;
      default: pr = PRIO_W'($urandom);
    endcase
    r = $urandom_range(99);
    if (r < insert_pct) begin
      send_command(ACT_INSERT, id, pr);
    end else begin
      r = $urandom_range(99);
      if (r < 40) begin
        send_command(ACT_POP, id, pr);
      end else if (r < 85) begin
        if (stored_count != 0 && $urandom_range(99) < 70)
          id = stored_ids[$urandom_range(stored_count - 1)];
        send_command(ACT_REMOVE, id, pr);
      end else begin
        send_command(ACT_DUMP, id, pr);
      end
    end
  endtask

  task automatic test_empty_store();
    send_command(ACT_POP, 16'h0000, 8'h00);
    send_command(ACT_REMOVE, 16'h1234, 8'h00);
    send_command(ACT_DUMP, 16'hFFFF, 8'hFF);
  endtask

  task automatic test_fill_to_full();
    send_command(ACT_INSERT, 16'h0000, 8'h00);
    send_command(ACT_INSERT, 16'hFFFF, 8'hFF);
    send_command(ACT_INSERT, 16'h0011, 8'h80);
    send_command(ACT_INSERT, 16'h0011, 8'hC0);
    for (int unsigned i = 0; i < SLOTS - 4; i++)
      send_command(ACT_INSERT, 16'hA5A0 + ID_W'(i), PRIO_W'((i % 3) * 'h40 + 'h40));
    send_command(ACT_INSERT, 16'h5A5A, 8'h7F);
    send_command(ACT_DUMP, 16'h0000, 8'h00);
  endtask

  task automatic test_remove_cases();
    send_command(ACT_REMOVE, 16'h0011, 8'h00);
    send_command(ACT_REMOVE, 16'h0011, 8'h00);
    send_command(ACT_REMOVE, 16'h0011, 8'h00);
    send_command(ACT_POP, 16'h0000, 8'h00);
    send_command(ACT_DUMP, 16'h0000, 8'h00);
  endtask

  task automatic test_random_mix(int unsigned n);
    for (int unsigned i = 0; i < n; i++) send_random_command();
  endtask

  task automatic test_no_idle(int unsigned n);
    sender_idle_en = 1'b0;
    receiver_idle_en = 1'b0;
    for (int unsigned i = 0; i < n; i++) send_random_command();
    sender_idle_en = 1'b1;
    receiver_idle_en = 1'b1;
  endtask

  // The receiver holds off long enough for the block to back up into its input.
  task automatic test_output_backpressure();
    hold_left = 150;
    for (int unsigned i = 0; i < 12; i++)
      send_command(ACT_INSERT, ID_W'($urandom), PRIO_W'($urandom));
    send_command(ACT_DUMP, 16'h0000, 8'h00);
    for (int unsigned i = 0; i < 8; i++)
      send_command(ACT_POP, 16'h0000, 8'h00);
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    action_i = '0;
    task_id_i = '0;
    task_priority_i = '0;
    out_stall_i = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_store();
    test_fill_to_full();
    test_remove_cases();
    test_random_mix(150);
    test_output_backpressure();
    test_no_idle(80);
    test_random_mix(43);

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
